// ===== design/abslt_pkg.sv =====
// ----------------------------------------------------------------------------
// Absolute loader deframer package
// Shared types and constants for the front queue and the block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package abslt_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned HdrLen  = 6;  // sync, count and address bytes

  typedef enum logic [KindW-1:0] {
    EV_WRITE = 2'd0,
    EV_DONE  = 2'd1,
    EV_ERROR = 2'd2
  } event_kind_e;

  // One classified tape item as it travels from the front to the back.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eot;
    logic             is_one;
    logic             is_zero;
  } tok_t;

endpackage : abslt_pkg

`default_nettype wire

// ===== design/abslt_front.sv =====
// ----------------------------------------------------------------------------
// Absolute loader front end
// Accept tape items, classify each byte and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module abslt_front
  import abslt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] tape_byte_i,
  input  wire logic             end_of_tape_i,
  output logic                  tok_valid_o,
  output tok_t                  tok_o,
  input  wire logic             tok_pop_i
);

  tok_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  tok_t       tok_in;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = mem_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = tok_pop_i && tok_valid_o;

  always_comb begin
    tok_in.data    = tape_byte_i;
    tok_in.eot     = end_of_tape_i;
    tok_in.is_one  = (tape_byte_i == 8'd1);
    tok_in.is_zero = (tape_byte_i == 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= tok_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule : abslt_front

`default_nettype wire

// ===== design/abslt_back.sv =====
// ----------------------------------------------------------------------------
// Absolute loader back end
// Walk the block format one item a cycle while the output is not stalled, and register the resulting event.
// ----------------------------------------------------------------------------
`default_nettype none

module abslt_back
  import abslt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tok_valid_i,
  input  wire tok_t             tok_i,
  output logic                  tok_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [KindW-1:0]      event_kind_o,
  output logic [WordW-1:0]      write_address_o,
  output logic [ByteW-1:0]      write_data_o
);

  typedef enum logic [2:0] {
    PH_SYNC_LO, PH_SYNC_HI, PH_CNT_LO, PH_CNT_HI,
    PH_ADR_LO,  PH_ADR_HI,  PH_DATA,   PH_CKSUM
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] sum_q, sum_d, sum_add;
  logic [WordW-1:0] cnt_q, cnt_d;
  logic [WordW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] low_q, low_d;
  logic [WordW-1:0] word;

  logic             ev_fire;
  event_kind_e      ev_kind;
  logic [WordW-1:0] ev_addr;
  logic [ByteW-1:0] ev_data;

  logic             out_valid_q;
  event_kind_e      kind_q;
  logic [WordW-1:0] addr_out_q;
  logic [ByteW-1:0] data_out_q;
  logic             step;

  // Take an item whenever the output register is empty or being emptied.
  assign step      = tok_valid_i && (!out_valid_q || !out_stall_i);
  assign tok_pop_o = step;
  assign sum_add   = sum_q + tok_i.data;
  assign word      = {tok_i.data, low_q};

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    addr_d  = addr_q;
    low_d   = low_q;
    ev_fire = 1'b0;
    ev_kind = EV_WRITE;
    ev_addr = '0;
    ev_data = '0;

    if (tok_i.eot) begin
      ev_fire = 1'b1;
      ev_kind = (phase_q == PH_SYNC_LO || phase_q == PH_SYNC_HI) ? EV_DONE : EV_ERROR;
    end else begin
      sum_d = sum_add;
      unique case (phase_q)
        PH_SYNC_LO: begin
          if (tok_i.is_one) begin
            sum_d   = 8'd1;
            phase_d = PH_SYNC_HI;
          end else begin
            sum_d   = '0;
          end
        end
        PH_SYNC_HI: begin
          if (tok_i.is_zero) begin
            phase_d = PH_CNT_LO;
          end else begin
            phase_d = PH_SYNC_LO;
            sum_d   = '0;
          end
        end
        PH_CNT_LO: begin
          low_d   = tok_i.data;
          phase_d = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          cnt_d   = word;
          phase_d = PH_ADR_LO;
        end
        PH_ADR_LO: begin
          low_d   = tok_i.data;
          phase_d = PH_ADR_HI;
        end
        PH_ADR_HI: begin
          if (tok_i.is_zero && low_q == 8'd1) begin
            ev_fire = 1'b1;
            ev_kind = EV_DONE;
          end else if (cnt_q == '0) begin
            phase_d = PH_SYNC_LO;
            sum_d   = '0;
          end else if (cnt_q < WordW'(HdrLen)) begin
            ev_fire = 1'b1;
            ev_kind = EV_ERROR;
          end else begin
            cnt_d   = cnt_q - WordW'(HdrLen);
            addr_d  = word;
            phase_d = (cnt_q == WordW'(HdrLen)) ? PH_CKSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          addr_d  = addr_q + 16'd1;
          cnt_d   = cnt_q - 16'd1;
          if (cnt_q == 16'd1) phase_d = PH_CKSUM;
          ev_fire = 1'b1;
          ev_kind = EV_WRITE;
          ev_addr = addr_q;
          ev_data = tok_i.data;
        end
        PH_CKSUM: begin
          if (sum_add != '0) begin
            ev_fire = 1'b1;
            ev_kind = EV_ERROR;
          end else begin
            phase_d = PH_SYNC_LO;
            sum_d   = '0;
          end
        end
        default: phase_d = PH_SYNC_LO;
      endcase
    end

    // Drop all block state after a done or error event.
    if (ev_fire && ev_kind != EV_WRITE) begin
      phase_d = PH_SYNC_LO;
      sum_d   = '0;
      cnt_d   = '0;
      addr_d  = '0;
      low_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC_LO;
      sum_q       <= '0;
      cnt_q       <= '0;
      addr_q      <= '0;
      low_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= EV_WRITE;
      addr_out_q  <= '0;
      data_out_q  <= '0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        sum_q   <= sum_d;
        cnt_q   <= cnt_d;
        addr_q  <= addr_d;
        low_q   <= low_d;
        out_valid_q <= ev_fire;
        if (ev_fire) begin
          kind_q     <= ev_kind;
          addr_out_q <= ev_addr;
          data_out_q <= ev_data;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign write_address_o = addr_out_q;
  assign write_data_o    = data_out_q;

endmodule : abslt_back

`default_nettype wire

// ===== design/absolute_loader_tape_deframer_core.sv =====
// ----------------------------------------------------------------------------
// Absolute loader tape deframer
// Turn a paper-tape byte stream in absolute-loader block format into memory
// byte writes and a final done or error event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one tape item (tape_byte_i,
//   end_of_tape_i) per transfer. Output channel: out_valid_o / out_stall_i
//   carry one event (event_kind_o, write_address_o, write_data_o).
//   Kind EV_WRITE is a byte write; EV_DONE ends the load (address 1 block or
//   end of tape while hunting for sync); EV_ERROR flags a bad count, a bad
//   checksum or a tape that ends inside a block. Address and data read zero
//   for the last two kinds.
//   Throughput: one item per cycle unless the receiver stalls; the decoder takes an item at each step.
//   Path: an item is written into the front queue when it is transferred, and
//   is decoded into the output register when the decoder takes it, which a
//   receiver stall can delay; the event is then offered on the output.
//   Reset: the queue empties and the decoder returns to the sync search; no
//   clearing pass is needed. After a done or error event the decoder
//   returns to the same state, ready for a new tape.
//   Receiver stall: the output register holds its event, the decoder stops
//   taking items, the two-entry front queue fills and then raises in_stall_o.
// ----------------------------------------------------------------------------
`default_nettype none

module absolute_loader_tape_deframer_core
  import abslt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] tape_byte_i,
  input  wire logic             end_of_tape_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [KindW-1:0]      event_kind_o,
  output logic [WordW-1:0]      write_address_o,
  output logic [ByteW-1:0]      write_data_o
);

  // Classified items between the front queue and the decoder.
  logic tok_valid;
  logic tok_pop;
  tok_t tok;

  // Front: accept and classify, buffer so that the decoder may stall alone.
  abslt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tape_byte_i   (tape_byte_i),
    .end_of_tape_i (end_of_tape_i),
    .tok_valid_o   (tok_valid),
    .tok_o         (tok),
    .tok_pop_i     (tok_pop)
  );

  // Back: advance the block format and register one event per item at most.
  abslt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_valid_i     (tok_valid),
    .tok_i           (tok),
    .tok_pop_o       (tok_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o)
  );

endmodule : absolute_loader_tape_deframer_core

`default_nettype wire
